// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pftc_pkg.sv -----
// shared types, constants and helper functions for the floor texcoord block
// no dependencies
`default_nettype none

package pftc_pkg;

	localparam int DEF_SCREEN_WIDTH     = 640;
	localparam int DEF_TILE_WIDTH_LOG2  = 8;
	localparam int DEF_TILE_HEIGHT_LOG2 = 8;
	localparam int QUEUE_DEPTH          = 2;

	localparam logic [2:0] REG_COS     = 3'd0;
	localparam logic [2:0] REG_SIN     = 3'd1;
	localparam logic [2:0] REG_CAM_X   = 3'd2;
	localparam logic [2:0] REG_CAM_Y   = 3'd3;
	localparam logic [2:0] REG_DEPTH   = 3'd4;
	localparam logic [2:0] REG_SCALE_X = 3'd5;
	localparam logic [2:0] REG_HORIZON = 3'd6;

	localparam logic signed [15:0] RST_COS     = 16'sd16384;
	localparam logic signed [15:0] RST_SIN     = 16'sd0;
	localparam logic [23:0]        RST_DEPTH   = 24'd256;
	localparam logic [15:0]        RST_SCALE_X = 16'd256;

	typedef struct packed {
		logic               row_ok;
		logic signed [31:0] step_x;
		logic signed [31:0] step_y;
		logic signed [39:0] start_x;
		logic signed [39:0] start_y;
	} row_terms_t;

	typedef struct packed {
		logic [9:0] screen_x;
		row_terms_t terms;
	} qent_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v[34:31] != {4{v[34]}})
			r = v[34] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
		logic signed [39:0] r;
		if (v[47:39] != {9{v[47]}})
			r = v[47] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
		else
			r = v[39:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/pftc_div.sv -----
// restoring 32-by-16-bit divider, one quotient bit per cycle
// uses pftc_pkg request and response types
`default_nettype none

module pftc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pftc_pkg::div_req_t req,
	output pftc_pkg::div_rsp_t     rsp
);

	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] shifted;
	logic [16:0] diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[16]) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[15:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// ----- rtl/pftc_front.sv -----
// front end: config registers, row cache check and row term sequencer
// uses pftc_pkg and the pftc_div divider
`default_nettype none

module pftc_front #(
	parameter int SCREEN_WIDTH = pftc_pkg::DEF_SCREEN_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [23:0]      cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [9:0]       in_sx,
	input  wire logic [8:0]       in_sy,
	output logic                  push,
	output pftc_pkg::qent_t       push_ent,
	input  wire logic             q_full
);

	localparam logic signed [12:0] HALF = 13'(SCREEN_WIDTH / 2);

	typedef enum logic [2:0] {S_RUN, S_DIV1, S_DIV2, S_MUL, S_PUSH} state_t;

	state_t state_q;

	logic signed [15:0] cos_q, sin_q;
	logic signed [23:0] cam_x_q, cam_y_q;
	logic [23:0]        depth_q;
	logic [15:0]        scale_x_q;
	logic signed [10:0] horizon_q;

	logic [8:0]  cached_row_q;
	logic        cache_valid_q;
	pftc_pkg::row_terms_t terms_q;
	logic [9:0]  sx_q;
	logic        dist_neg_q;
	logic [23:0] dist_q;
	logic [31:0] hs_q;
	logic [2:0]  step_q;
	logic [47:0] prod_q;
	logic signed [34:0] rx_q;
	logic signed [44:0] hpx_q, hpy_q;

	pftc_pkg::div_req_t div_req;
	pftc_pkg::div_rsp_t div_rsp;
	logic        div_start_q;
	logic [31:0] div_dividend_q;
	logic [15:0] div_divisor_q;

	logic signed [11:0] d;
	logic [10:0] d_abs;
	logic        hit, acc;
	logic        sin_neg, cos_neg;
	logic [15:0] sin_mag, cos_mag;
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic signed [34:0] m_pos, m_neg;
	logic signed [47:0] sum_x, sum_y;

	assign cfg_ready = 1'b1;
	assign d       = $signed({3'b000, in_sy}) + $signed({horizon_q[10], horizon_q});
	assign d_abs   = d[11] ? 11'(-d) : d[10:0];
	assign hit     = cache_valid_q && (in_sy == cached_row_q);
	assign in_ready = (state_q == S_RUN) && !q_full;
	assign acc     = in_valid && in_ready;

	assign sin_neg = sin_q[15];
	assign cos_neg = cos_q[15];
	assign sin_mag = sin_neg ? 16'(-sin_q) : sin_q;
	assign cos_mag = cos_neg ? 16'(-cos_q) : cos_q;

	always_comb begin
		mul_a = hs_q;
		mul_b = sin_mag;
		case (step_q)
			3'd0: begin mul_a = hs_q;          mul_b = sin_mag; end
			3'd1: begin mul_a = hs_q;          mul_b = cos_mag; end
			3'd2: begin mul_a = {8'd0, dist_q}; mul_b = cos_mag; end
			default: begin mul_a = {8'd0, dist_q}; mul_b = sin_mag; end
		endcase
	end

	assign m_pos = $signed({1'b0, prod_q[47:14]});
	assign m_neg = -m_pos;
	assign sum_x = 48'(cam_x_q) + 48'(rx_q) - 48'(hpx_q);
	assign sum_y = 48'(cam_y_q) + 48'((sin_neg ^ dist_neg_q) ? m_neg : m_pos) - 48'(hpy_q);

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_dividend_q;
	assign div_req.divisor  = div_divisor_q;

	pftc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		push = 1'b0;
		push_ent.screen_x = sx_q;
		push_ent.terms    = terms_q;
		if (state_q == S_RUN) begin
			push = acc && hit;
			push_ent.screen_x = in_sx;
		end else if (state_q == S_PUSH) begin
			push = !q_full;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q     <= pftc_pkg::RST_COS;
			sin_q     <= pftc_pkg::RST_SIN;
			cam_x_q   <= '0;
			cam_y_q   <= '0;
			depth_q   <= pftc_pkg::RST_DEPTH;
			scale_x_q <= pftc_pkg::RST_SCALE_X;
			horizon_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pftc_pkg::REG_COS:     cos_q     <= cfg_data[15:0];
				pftc_pkg::REG_SIN:     sin_q     <= cfg_data[15:0];
				pftc_pkg::REG_CAM_X:   cam_x_q   <= cfg_data;
				pftc_pkg::REG_CAM_Y:   cam_y_q   <= cfg_data;
				pftc_pkg::REG_DEPTH:   depth_q   <= cfg_data;
				pftc_pkg::REG_SCALE_X: scale_x_q <= cfg_data[15:0];
				pftc_pkg::REG_HORIZON: horizon_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_RUN;
			cache_valid_q <= 1'b0;
			cached_row_q  <= '0;
			terms_q       <= '0;
			div_start_q   <= 1'b0;
			step_q        <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (cfg_valid && cfg_index <= pftc_pkg::REG_HORIZON)
				cache_valid_q <= 1'b0;
			unique case (state_q)
				S_RUN: begin
					if (acc && !hit) begin
						cached_row_q  <= in_sy;
						cache_valid_q <= 1'b1;
						if (d == 12'sd0 || scale_x_q == 16'd0) begin
							terms_q <= '0;
							state_q <= S_PUSH;
						end else begin
							terms_q.row_ok <= 1'b1;
							div_start_q    <= 1'b1;
							state_q        <= S_DIV1;
						end
					end
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						3'd1: terms_q.step_x <= pftc_pkg::sat32(
							(sin_neg ^ dist_neg_q) ? m_pos : m_neg);
						3'd2: terms_q.step_y <= pftc_pkg::sat32(
							(cos_neg ^ dist_neg_q) ? m_neg : m_pos);
						3'd5: terms_q.start_x <= pftc_pkg::sat40(sum_x);
						3'd6: begin
							terms_q.start_y <= pftc_pkg::sat40(sum_y);
							state_q <= S_PUSH;
						end
						default: ;
					endcase
				end
				S_PUSH: begin
					if (!q_full)
						state_q <= S_RUN;
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

	// row datapath
	always_ff @(posedge clk) begin
		if (state_q == S_RUN && acc && !hit) begin
			sx_q           <= in_sx;
			dist_neg_q     <= d[11];
			div_dividend_q <= {8'd0, depth_q};
			div_divisor_q  <= {5'd0, d_abs};
		end
		if (state_q == S_DIV1 && div_rsp.done) begin
			dist_q         <= div_rsp.quotient[23:0];
			div_dividend_q <= {div_rsp.quotient[23:0], 8'd0};
			div_divisor_q  <= scale_x_q;
		end
		if (state_q == S_DIV2 && div_rsp.done)
			hs_q <= div_rsp.quotient;
		if (state_q == S_MUL) begin
			prod_q <= mul_a * mul_b;
			case (step_q)
				3'd3: rx_q <= (cos_neg ^ dist_neg_q) ? m_neg : m_pos;
				3'd4: hpx_q <= 45'(HALF * terms_q.step_x);
				3'd5: hpy_q <= 45'(HALF * terms_q.step_y);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pftc_queue.sv -----
// small register queue between front and back
// uses pftc_pkg entry type
`default_nettype none

module pftc_queue #(
	parameter int DEPTH = pftc_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pftc_pkg::qent_t push_ent,
	input  wire logic            pop,
	output pftc_pkg::qent_t      head,
	output logic                 not_empty,
	output logic                 full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	pftc_pkg::qent_t mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign not_empty = cnt_q != '0;
	assign full      = cnt_q == (PW+1)'(DEPTH);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_ent;
	end

endmodule

`default_nettype wire

// ----- rtl/pftc_back.sv -----
// back end: per-pixel multiply-add, truncation, tile wrap and output register
// uses pftc_pkg entry type
`default_nettype none

module pftc_back #(
	parameter int TILE_WIDTH_LOG2  = pftc_pkg::DEF_TILE_WIDTH_LOG2,
	parameter int TILE_HEIGHT_LOG2 = pftc_pkg::DEF_TILE_HEIGHT_LOG2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pftc_pkg::qent_t head,
	input  wire logic            not_empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           tex_x,
	output logic [7:0]           tex_y,
	output logic                 coord_valid
);

	logic               valid_s1, valid_q;
	logic               ok_s1;
	logic signed [42:0] prx_s1, pry_s1;
	logic signed [39:0] stx_s1, sty_s1;
	logic [7:0]         tx_q, ty_q;
	logic               ok_q;
	logic               en;
	logic signed [43:0] pos_x, pos_y;
	logic signed [43:0] px, py;

	function automatic logic [7:0] wrap(input logic signed [43:0] p, input int lg);
		logic [7:0] r;
		for (int i = 0; i < 8; i++)
			r[i] = (i < lg) ? p[i] : 1'b0;
		return r;
	endfunction

	assign en  = !valid_q || out_ready;
	assign pop = not_empty && (!valid_s1 || en);

	assign pos_x = 44'(stx_s1) + 44'(prx_s1);
	assign pos_y = 44'(sty_s1) + 44'(pry_s1);
	// divide by 256 toward zero
	assign px = (pos_x + (pos_x[43] ? 44'sd255 : 44'sd0)) >>> 8;
	assign py = (pos_y + (pos_y[43] ? 44'sd255 : 44'sd0)) >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (!valid_s1 || en)
				valid_s1 <= not_empty;
			if (en)
				valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ok_s1  <= head.terms.row_ok;
			prx_s1 <= $signed({1'b0, head.screen_x}) * head.terms.step_x;
			pry_s1 <= $signed({1'b0, head.screen_x}) * head.terms.step_y;
			stx_s1 <= head.terms.start_x;
			sty_s1 <= head.terms.start_y;
		end
		if (en && valid_s1) begin
			ok_q <= ok_s1;
			tx_q <= ok_s1 ? wrap(px, TILE_WIDTH_LOG2) : 8'd0;
			ty_q <= ok_s1 ? wrap(py, TILE_HEIGHT_LOG2) : 8'd0;
		end
	end

	assign out_valid   = valid_q;
	assign tex_x       = tx_q;
	assign tex_y       = ty_q;
	assign coord_valid = ok_q;

endmodule

`default_nettype wire

// ----- rtl/perspective_floor_texcoord.sv -----
// top level of the perspective floor texture coordinate generator
// uses pftc_pkg, pftc_front, pftc_queue and pftc_back
//
// channel   dir  beat contents
// s_*       in   tdata: screen_x[9:0], screen_y[18:10]
// m_*       out  tdata: tex_x[7:0], tex_y[15:8], coord_valid[16]
// cfg_*     in   cfg_index register number, cfg_data value
//
// pixels on the cached row: one beat per cycle while the queue is not full
// a row change runs two divides on the shared divider plus seven multiply
// and sum steps, during which s_tready is low
// a full output register and queue hold s_tready low; reset drops the cached row

`default_nettype none

module perspective_floor_texcoord #(
	parameter int SCREEN_WIDTH     = pftc_pkg::DEF_SCREEN_WIDTH,
	parameter int TILE_WIDTH_LOG2  = pftc_pkg::DEF_TILE_WIDTH_LOG2,
	parameter int TILE_HEIGHT_LOG2 = pftc_pkg::DEF_TILE_HEIGHT_LOG2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // screen_x, screen_y
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // tex_x, tex_y, coord_valid
);

	pftc_pkg::qent_t push_ent, head;
	logic push, pop, not_empty, full;
	logic [7:0] tex_x, tex_y;
	logic coord_valid;

	pftc_front #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sx     (s_tdata[9:0]),
		.in_sy     (s_tdata[18:10]),
		.push      (push),
		.push_ent  (push_ent),
		.q_full    (full)
	);

	pftc_queue #(.DEPTH(pftc_pkg::QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	pftc_back #(
		.TILE_WIDTH_LOG2  (TILE_WIDTH_LOG2),
		.TILE_HEIGHT_LOG2 (TILE_HEIGHT_LOG2)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.not_empty   (not_empty),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.tex_x       (tex_x),
		.tex_y       (tex_y),
		.coord_valid (coord_valid)
	);

	assign m_tdata = {7'd0, coord_valid, tex_y, tex_x};

endmodule

`default_nettype wire

// ----- rtl/pftc_chk.sv -----
// port-level checker for perspective_floor_texcoord, bound to the top level
// uses assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pftc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	`CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat dropped")
	`CHK_SAME(a_invalid_zero, m_tvalid && !m_tdata[16], m_tdata[15:0] == 16'd0, "invalid coord not zero")
	`CHK_SAME(a_pad_zero, m_tvalid, m_tdata[23:17] == 7'd0, "tdata padding set")

endmodule

bind perspective_floor_texcoord pftc_chk u_chk (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
// self-checking testbench for perspective_floor_texcoord: pixel beats with random gaps,
// texel predictions compared field by field at the output beat
// depends on pftc_pkg and the perspective_floor_texcoord rtl
`default_nettype none

module tb_top;

	localparam int HALF_WIDTH = pftc_pkg::DEF_SCREEN_WIDTH / 2;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		logic [9:0] col;
		logic [8:0] row;
	} pixel_t;

	typedef struct {
		logic [7:0] tex_x;
		logic [7:0] tex_y;
		logic       ok;
	} texel_t;

	typedef struct {
		logic [2:0]  idx;
		logic [23:0] val;
	} reg_write_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // screen_x, screen_y
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // tex_x, tex_y, coord_valid

	perspective_floor_texcoord DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// floor model state
	longint cos_a = 16384, sin_a = 0, cam_x = 0, cam_y = 0;
	longint depth = 256, scale_x = 256, horizon = 0;
	logic [8:0] row_cached = '0;
	logic       row_cached_ok = 1'b0;
	logic       row_good = 1'b0;
	longint dx = 0, dy = 0, org_x = 0, org_y = 0;

	pixel_t pixel_q[$];
	texel_t texel_q[$];
	int     errors = 0;
	int     idle_cycles = 0;

	function automatic longint sext_to(input logic [23:0] v, input int w);
		longint r;
		r = longint'(v) & ((64'sd1 <<< w) - 1);
		if (r >= (64'sd1 <<< (w - 1)))
			r = r - (64'sd1 <<< w);
		return r;
	endfunction

	function automatic longint clamp_to(input longint v, input int w);
		longint hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [23:0] val);
		case (idx)
			pftc_pkg::REG_COS:     cos_a = sext_to(val, 16);
			pftc_pkg::REG_SIN:     sin_a = sext_to(val, 16);
			pftc_pkg::REG_CAM_X:   cam_x = sext_to(val, 24);
			pftc_pkg::REG_CAM_Y:   cam_y = sext_to(val, 24);
			pftc_pkg::REG_DEPTH:   depth = longint'(val);
			pftc_pkg::REG_SCALE_X: scale_x = longint'(val[15:0]);
			pftc_pkg::REG_HORIZON: horizon = sext_to(val, 11);
			default:     return;
		endcase
		row_cached_ok = 1'b0;
	endfunction

	function automatic texel_t floor_texel(input pixel_t p);
		texel_t t;
		longint d, row_dist, hs, px, py;
		if (!row_cached_ok || p.row != row_cached) begin
			row_cached = p.row;
			row_cached_ok = 1'b1;
			d = longint'(p.row) + horizon;
			if (d == 0 || scale_x == 0) begin
				row_good = 1'b0;
				dx = 0; dy = 0; org_x = 0; org_y = 0;
			end else begin
				row_good = 1'b1;
				row_dist = depth / d;
				hs = (row_dist * 256) / scale_x;
				dx = clamp_to(-(sin_a * hs) / 16384, 32);
				dy = clamp_to((cos_a * hs) / 16384, 32);
				org_x = clamp_to(cam_x + (row_dist * cos_a) / 16384 - HALF_WIDTH * dx, 40);
				org_y = clamp_to(cam_y + (row_dist * sin_a) / 16384 - HALF_WIDTH * dy, 40);
			end
		end
		if (!row_good) begin
			t.tex_x = '0; t.tex_y = '0; t.ok = 1'b0;
		end else begin
			px = (org_x + longint'(p.col) * dx) / 256;
			py = (org_y + longint'(p.col) * dy) / 256;
			t.tex_x = px[7:0];
			t.tex_y = py[7:0];
			t.ok = 1'b1;
		end
		return t;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// pixel driver
	pixel_t cur_px;
	int     send_gap = 0;
	logic   send_busy;
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			send_busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				texel_q.push_back(floor_texel(cur_px));
				send_busy = 1'b0;
			end
			if (!send_busy) begin
				if (send_gap > 0)
					send_gap--;
				else if (pixel_q.size() > 0) begin
					cur_px = pixel_q.pop_front();
					send_busy = 1'b1;
					send_gap = pick_gap();
				end
			end
			s_tvalid <= send_busy;
			s_tdata <= {5'b0, cur_px.row, cur_px.col};
		end
	end

	// texel monitor, with one long hold-off after the first couple of hundred beats
	int     recv_gap = 0;
	int     recv_beats = 0;
	texel_t want;
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else begin
			if (m_tvalid && m_tready) begin
				recv_beats++;
				if (texel_q.size() == 0) begin
					$display("%0t: unexpected beat, actual %h", $time, m_tdata);
					errors++;
				end else begin
					want = texel_q.pop_front();
					if (m_tdata[7:0] !== want.tex_x) begin
						$display("%0t: tex_x expected %h actual %h", $time, want.tex_x,
							m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[15:8] !== want.tex_y) begin
						$display("%0t: tex_y expected %h actual %h", $time, want.tex_y,
							m_tdata[15:8]);
						errors++;
					end
					if (m_tdata[16] !== want.ok) begin
						$display("%0t: coord_valid expected %b actual %b", $time, want.ok,
							m_tdata[16]);
						errors++;
					end
				end
				if (recv_beats == 200)
					recv_gap = 400;
				else
					recv_gap = pick_gap();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("perspective_floor_texcoord verification failed");
				$finish;
			end
		end
	end

	task automatic write_regs(input reg_write_t w[$]);
		cfg_valid <= 1'b1;
		foreach (w[i]) begin
			cfg_index <= w[i].idx;
			cfg_data <= w[i].val;
			do @(posedge clk); while (!cfg_ready);
			apply_reg(w[i].idx, w[i].val);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pixel_q.size() > 0 || s_tvalid || texel_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_signed(input int lim);
		int v;
		v = int'($urandom_range(0, 2 * lim)) - lim;
		return 24'(v);
	endfunction

	task automatic push_pixel(input int col, input int row);
		pixel_t p;
		p.col = col[9:0];
		p.row = row[8:0];
		pixel_q.push_back(p);
	endtask

	// runs along one row, some isolated pixels and some on the degenerate row
	task automatic random_pixels(input int n);
		int row, len, col;
		while (n > 0) begin
			if ($urandom_range(0, 9) == 0)
				row = $urandom_range(0, 511);
			else if ($urandom_range(0, 9) == 0 && horizon <= 0 && horizon > -512)
				row = -horizon;
			else
				row = $urandom_range(0, 479);
			len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 30);
			repeat (len) begin
				col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
					: $urandom_range(0, 639);
				push_pixel(col, row);
				n--;
			end
		end
	endtask

	reg_write_t ws[$];
	reg_write_t one;
	int         ph;
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: degenerate row zero, extreme columns and rows
		push_pixel(0, 0);
		push_pixel(1023, 0);
		push_pixel(0, 1);
		push_pixel(639, 1);
		push_pixel(1023, 1);
		push_pixel(341, 1);
		push_pixel(682, 479);
		push_pixel(0, 511);
		push_pixel(1023, 511);
		push_pixel(5, 0);
		drain();

		// extremes, zero scale, unknown index, then random settings
		for (ph = 0; ph < 14; ph++) begin
			ws.delete();
			case (ph)
				0: begin
					one.idx = pftc_pkg::REG_COS;     one.val = 24'hFFC000; ws.push_back(one);
					one.idx = pftc_pkg::REG_SIN;     one.val = 24'h004000; ws.push_back(one);
					one.idx = pftc_pkg::REG_CAM_X;   one.val = 24'h7FFFFF; ws.push_back(one);
					one.idx = pftc_pkg::REG_CAM_Y;   one.val = 24'h800000; ws.push_back(one);
					one.idx = pftc_pkg::REG_DEPTH;   one.val = 24'hFFFFFF; ws.push_back(one);
					one.idx = pftc_pkg::REG_SCALE_X; one.val = 24'h000001; ws.push_back(one);
					one.idx = pftc_pkg::REG_HORIZON; one.val = 24'h000400; ws.push_back(one);
				end
				1: begin
					one.idx = pftc_pkg::REG_HORIZON; one.val = 24'h0003FF; ws.push_back(one);
					one.idx = pftc_pkg::REG_SCALE_X; one.val = 24'h00FFFF; ws.push_back(one);
					one.idx = pftc_pkg::REG_DEPTH;   one.val = 24'h000000; ws.push_back(one);
					one.idx = pftc_pkg::REG_SIN;     one.val = 24'hFFC000; ws.push_back(one);
				end
				2: begin
					one.idx = pftc_pkg::REG_SCALE_X; one.val = 24'h000000; ws.push_back(one);
					one.idx = pftc_pkg::REG_DEPTH;   one.val = 24'h012345; ws.push_back(one);
				end
				3: begin
					one.idx = pftc_pkg::REG_SCALE_X; one.val = 24'h000100; ws.push_back(one);
					one.idx = pftc_pkg::REG_HORIZON; one.val = 24'hFFFF9C; ws.push_back(one);
					one.idx = REG_UNUSED;  one.val = 24'hFFFFFF; ws.push_back(one);
				end
				default: begin
					one.idx = pftc_pkg::REG_COS;
					one.val = rand_signed(16384); ws.push_back(one);
					one.idx = pftc_pkg::REG_SIN;
					one.val = rand_signed(16384); ws.push_back(one);
					one.idx = pftc_pkg::REG_CAM_X; one.val = 24'($urandom); ws.push_back(one);
					one.idx = pftc_pkg::REG_CAM_Y; one.val = 24'($urandom); ws.push_back(one);
					one.idx = pftc_pkg::REG_DEPTH;
					one.val = ($urandom_range(0, 3) == 0) ? 24'($urandom)
						: 24'($urandom_range(0, 65535));
					ws.push_back(one);
					one.idx = pftc_pkg::REG_SCALE_X;
					one.val = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 65535))
						: 24'($urandom_range(16, 1024));
					ws.push_back(one);
					one.idx = pftc_pkg::REG_HORIZON;
					one.val = ($urandom_range(0, 2) == 0) ? rand_signed(1024)
						: rand_signed(300);
					ws.push_back(one);
					if ($urandom_range(0, 3) == 0) begin
						one.idx = REG_UNUSED; one.val = 24'($urandom); ws.push_back(one);
					end
				end
			endcase
			write_regs(ws);
			random_pixels(ph < 4 ? 40 : 140);
			drain();
		end

		if (errors == 0)
			$display("perspective_floor_texcoord verification clean");
		else
			$display("perspective_floor_texcoord verification failed");
		$finish;
	end

endmodule

`default_nettype wire
